// ===== src/vad_pkg.sv =====
// Shared types, widths and the arctangent table for the vector angle block.
// Used by every module under src; depends on nothing.
`default_nettype none
package vad_pkg;

   localparam int CoordWidth    = 16;
   localparam int AngleFracBits = 7;
   localparam int CordicStages  = 16;

   localparam int GuardBits     = 24;
   localparam int AccFrac       = 24;
   localparam int TableLen      = 32;
   localparam int StageIdxWidth = $clog2(TableLen);

   localparam int MagWidth      = CoordWidth + 1;
   localparam int RegWidth      = MagWidth + GuardBits + 3;
   localparam int ZWidth        = 32;
   localparam int AngWidth      = 33;
   localparam int OutWidth      = 16;
   localparam int RoundShift    = AccFrac - AngleFracBits;
   localparam int RndWidth      = AngWidth + 1 - RoundShift;

   localparam logic [AngWidth-1:0] Ang90  = AngWidth'(90)  << AccFrac;
   localparam logic [AngWidth-1:0] Ang180 = AngWidth'(180) << AccFrac;
   localparam logic [AngWidth-1:0] Ang270 = AngWidth'(270) << AccFrac;
   localparam logic [AngWidth-1:0] Ang360 = AngWidth'(360) << AccFrac;
   localparam logic [AngWidth:0]   RoundHalf = (AngWidth+1)'(1) << (RoundShift - 1);
   localparam logic [RndWidth-1:0] FullTurn  = RndWidth'(360) << AngleFracBits;

   localparam logic [ZWidth-1:0] AtanTable [TableLen] = '{
      32'd754974720, 32'd445687602, 32'd235489088, 32'd119537938,
      32'd60000934,  32'd30029717,  32'd15018523,  32'd7509720,
      32'd3754917,   32'd1877466,   32'd938734,    32'd469367,
      32'd234684,    32'd117342,    32'd58671,     32'd29335,
      32'd14668,     32'd7334,      32'd3667,      32'd1833,
      32'd917,       32'd458,       32'd229,       32'd115,
      32'd57,        32'd29,        32'd14,        32'd7,
      32'd4,         32'd2,         32'd1,         32'd0
   };

   typedef struct packed {
      logic x_neg;
      logic y_neg;
      logic x_zero;
      logic y_zero;
   } meta_type;

   typedef struct packed {
      logic signed [RegWidth-1:0] x;
      logic signed [RegWidth-1:0] y;
      logic signed [ZWidth-1:0]   z;
      meta_type                   meta;
   } cell_type;

endpackage
`default_nettype wire

// ===== src/vector_angle_degrees.sv =====
// Top level: vector angle in degrees through a row of CORDIC cells.
// Depends on vad_pkg, vad_prep, vad_cell and vad_finish.
//
//   channel  dir  tdata fields (low bit up)           tuser  tlast
//   req_     in   vec_x[15:0], vec_y[31:16]           -      -
//   rsp_     out  angle_out[15:0]                     -      -
//
// One beat in and one beat out per cycle while rsp_tready is high; the stages
// are the input register, 16 CORDIC cells and two finishing registers.
// Reset clears every stage's valid bit; payload registers are not reset.
// Each stage holds while the next one is full and stalled, so empty stages
// keep taking beats while a result waits on rsp_tready.
`default_nettype none
module vector_angle_degrees (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // vec_x[15:0], vec_y[31:16]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata    // angle_out[15:0]
);

   vad_pkg::cell_type stage_data  [vad_pkg::CordicStages+1];
   logic              stage_valid [vad_pkg::CordicStages+1];
   logic              stage_ready [vad_pkg::CordicStages+1];

   vad_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .out_valid (stage_valid[0]),
      .out_ready (stage_ready[0]),
      .out_data  (stage_data[0])
   );

   for (genvar g = 0; g < vad_pkg::CordicStages; g++) begin : g_cell
      vad_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .stage_idx (vad_pkg::StageIdxWidth'(g)),
         .in_valid  (stage_valid[g]),
         .in_ready  (stage_ready[g]),
         .in_data   (stage_data[g]),
         .out_valid (stage_valid[g+1]),
         .out_ready (stage_ready[g+1]),
         .out_data  (stage_data[g+1])
      );
   end

   vad_finish u_finish (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[vad_pkg::CordicStages]),
      .in_ready  (stage_ready[vad_pkg::CordicStages]),
      .in_data   (stage_data[vad_pkg::CordicStages]),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule
`default_nettype wire

// ===== src/vad_prep.sv =====
// Input register: takes a request beat, forms magnitudes, sign flags and zero flags.
// Depends on vad_pkg.
`default_nettype none
module vad_prep (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire logic [2*vad_pkg::CoordWidth-1:0] in_data,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output vad_pkg::cell_type             out_data
);

   logic                           valid_ff;
   vad_pkg::cell_type              data_ff;
   vad_pkg::cell_type              data_in;
   logic [vad_pkg::CoordWidth-1:0] raw_x;
   logic [vad_pkg::CoordWidth-1:0] raw_y;
   logic [vad_pkg::MagWidth-1:0]   mag_x;
   logic [vad_pkg::MagWidth-1:0]   mag_y;
   logic                           neg_x;
   logic                           neg_y;

   assign raw_x = in_data[vad_pkg::CoordWidth-1:0];
   assign raw_y = in_data[2*vad_pkg::CoordWidth-1:vad_pkg::CoordWidth];
   assign neg_x = raw_x[vad_pkg::CoordWidth-1];
   assign neg_y = raw_y[vad_pkg::CoordWidth-1];

   always_comb begin
      mag_x = neg_x ? (vad_pkg::MagWidth'(1) << vad_pkg::CoordWidth) - {1'b0, raw_x}
                    : {1'b0, raw_x};
      mag_y = neg_y ? (vad_pkg::MagWidth'(1) << vad_pkg::CoordWidth) - {1'b0, raw_y}
                    : {1'b0, raw_y};
      data_in.x           = vad_pkg::RegWidth'({mag_x, {vad_pkg::GuardBits{1'b0}}});
      data_in.y           = vad_pkg::RegWidth'({mag_y, {vad_pkg::GuardBits{1'b0}}});
      data_in.z           = '0;
      data_in.meta.x_neg  = neg_x;
      data_in.meta.y_neg  = neg_y;
      data_in.meta.x_zero = (raw_x == '0);
      data_in.meta.y_zero = (raw_y == '0);
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/vad_cell.sv =====
// One vectoring CORDIC cell: a micro-rotation and angle update per beat.
// Depends on vad_pkg.
`default_nettype none
module vad_cell (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic [vad_pkg::StageIdxWidth-1:0] stage_idx,
   input  wire logic                              in_valid,
   output logic                                   in_ready,
   input  wire vad_pkg::cell_type                 in_data,
   output logic                                   out_valid,
   input  wire logic                              out_ready,
   output vad_pkg::cell_type                      out_data
);

   logic                               valid_ff;
   vad_pkg::cell_type                  data_ff;
   vad_pkg::cell_type                  data_in;
   logic signed [vad_pkg::RegWidth-1:0] cx;
   logic signed [vad_pkg::RegWidth-1:0] cy;
   logic signed [vad_pkg::RegWidth-1:0] sx;
   logic signed [vad_pkg::RegWidth-1:0] sy;
   logic signed [vad_pkg::ZWidth-1:0]   step;

   assign cx   = in_data.x;
   assign cy   = in_data.y;
   assign sx   = cx >>> stage_idx;
   assign sy   = cy >>> stage_idx;
   assign step = $signed(vad_pkg::AtanTable[stage_idx]);

   always_comb begin
      data_in.meta = in_data.meta;
      if (!cy[vad_pkg::RegWidth-1]) begin
         data_in.x = cx + sy;
         data_in.y = cy - sx;
         data_in.z = in_data.z + step;
      end else begin
         data_in.x = cx - sy;
         data_in.y = cy + sx;
         data_in.z = in_data.z - step;
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/vad_finish.sv =====
// Output end: clamp the quadrant angle, place it by quadrant, round, wrap.
// Two registered steps; the second is the result register. Depends on vad_pkg.
`default_nettype none
module vad_finish (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire vad_pkg::cell_type             in_data,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output logic [vad_pkg::OutWidth-1:0]       out_data
);

   logic                              place_valid_ff;
   logic [vad_pkg::AngWidth-1:0]      ang_ff;
   logic [vad_pkg::AngWidth-1:0]      ang_in;
   logic [vad_pkg::AngWidth-1:0]      quad_t;
   logic                              place_ready;
   logic                              round_valid_ff;
   logic [vad_pkg::OutWidth-1:0]      angle_ff;
   logic [vad_pkg::OutWidth-1:0]      angle_in;
   logic                              round_ready;
   logic [vad_pkg::AngWidth:0]        rounded_sum;
   logic [vad_pkg::RndWidth-1:0]      rounded;
   vad_pkg::meta_type                 meta;

   assign meta = in_data.meta;

   always_comb begin
      if (in_data.z[vad_pkg::ZWidth-1]) begin
         quad_t = '0;
      end else if (vad_pkg::AngWidth'(in_data.z) > vad_pkg::Ang90) begin
         quad_t = vad_pkg::Ang90;
      end else begin
         quad_t = vad_pkg::AngWidth'(in_data.z);
      end
      if (meta.x_zero) begin
         if (meta.y_zero) begin
            ang_in = '0;
         end else begin
            ang_in = meta.y_neg ? vad_pkg::Ang90 : vad_pkg::Ang270;
         end
      end else if (meta.y_zero) begin
         ang_in = meta.x_neg ? vad_pkg::Ang180 : '0;
      end else if (!meta.x_neg && meta.y_neg) begin
         ang_in = quad_t;
      end else if (meta.x_neg && meta.y_neg) begin
         ang_in = vad_pkg::Ang180 - quad_t;
      end else if (meta.x_neg) begin
         ang_in = vad_pkg::Ang180 + quad_t;
      end else begin
         ang_in = vad_pkg::Ang360 - quad_t;
      end
   end

   always_comb begin
      rounded_sum = {1'b0, ang_ff} + vad_pkg::RoundHalf;
      rounded     = rounded_sum[vad_pkg::AngWidth:vad_pkg::RoundShift];
      if (rounded >= vad_pkg::FullTurn) begin
         rounded = rounded - vad_pkg::FullTurn;
      end
      angle_in = rounded[vad_pkg::OutWidth-1:0];
   end

   assign round_ready = !round_valid_ff || out_ready;
   assign place_ready = !place_valid_ff || round_ready;
   assign in_ready    = place_ready;
   assign out_valid   = round_valid_ff;
   assign out_data    = angle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         place_valid_ff <= 1'b0;
         round_valid_ff <= 1'b0;
      end else begin
         if (place_ready) begin
            place_valid_ff <= in_valid;
         end
         if (round_ready) begin
            round_valid_ff <= place_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (place_ready && in_valid) begin
         ang_ff <= ang_in;
      end
      if (round_ready && place_valid_ff) begin
         angle_ff <= angle_in;
      end
   end

endmodule
`default_nettype wire
